### sv/pde_pkg.sv
// pde_pkg: shared constants, character and status codes, and the
// controller/datapath command and status structs of the postfix evaluator.
// No dependencies.
package pde_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int WORD_W      = 32;
	localparam int SYM_W       = 8;
	localparam int STAT_W      = 2;

	localparam logic [SYM_W-1:0] CH_0     = 8'h30;
	localparam logic [SYM_W-1:0] CH_9     = 8'h39;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_DIV0      = 2'd1;
	localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd2;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd3;

	typedef struct packed {
		logic              load;
		logic              push;
		logic              set_err;
		logic [STAT_W-1:0] err;
		logic              apply;
		logic              div_start;
		logic              div_commit;
		logic              finish;
	} pde_cmd_t;

	typedef struct packed {
		logic err_nz;
		logic digit;
		logic full;
		logic few;
		logic is_div;
		logic b_zero;
		logic div_done;
		logic last;
	} pde_stat_t;

endpackage

### sv/pde_in_if.sv
// pde_in_if: input channel carrying one expression character per word.
// Depends on pde_pkg.
interface pde_in_if;
	logic                    valid;
	logic                    ready;
	logic [pde_pkg::SYM_W-1:0] symbol;
	logic                    last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink   (input valid, input symbol, input last, output ready);
endinterface

### sv/pde_out_if.sv
// pde_out_if: result channel carrying the evaluated value and its status.
// Depends on pde_pkg.
interface pde_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [pde_pkg::WORD_W-1:0] value;
	logic [pde_pkg::STAT_W-1:0]        status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

### sv/postfix_digit_evaluator_top.sv
// postfix_digit_evaluator_top: postfix expression evaluator, one character
// per word. Depends on pde_pkg, pde_in_if, pde_out_if, pde_ctrl, pde_datapath.
//
//   channel  | dir | payload                      | word
//   symbols  | in  | symbol[7:0], last            | one expression character
//   results  | out | value[31:0] signed, status[1:0] | one per expression end
//
// A digit is decoded and pushed; + - * and other characters add a read state,
// a division a divide state: the divider resolves one quotient bit per cycle.
// The final character adds a finish state to load the result register. Reset
// clears stack depth, the recent result and the error code; the stack RAM
// needs no clearing. A waiting result is held in its register while the next
// characters are taken; only the next expression end stalls until it is taken.
module postfix_digit_evaluator_top (
	input  logic      clk,
	input  logic      arst_n,
	pde_in_if.sink    symbols,
	pde_out_if.source results
);

	pde_pkg::pde_cmd_t  cmd;
	pde_pkg::pde_stat_t stat;

	pde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (symbols.valid),
		.in_ready (symbols.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pde_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat),
		.symbol(symbols.symbol),
		.last  (symbols.last),
		.value (results.value),
		.status(results.status)
	);

`ifndef SYNTHESIS
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.push, cmd.apply, cmd.div_start, cmd.div_commit, cmd.finish}))
		else $error("more than one datapath command at once");

	a_no_input_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !symbols.ready)
		else $error("input taken while the divider runs");

	a_finish_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> results.valid)
		else $error("result register loaded but not presented");

	a_div_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> !symbols.ready && !stat.err_nz)
		else $error("divider finished outside a division");
`endif

endmodule

### sv/pde_ram.sv
// pde_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/pde_divider.sv
// pde_divider: signed 32-bit divider, truncating toward zero, one quotient
// bit per cycle (restoring). Depends on pde_pkg.
module pde_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pde_pkg::WORD_W-1:0] dividend,
	input  logic [pde_pkg::WORD_W-1:0] divisor,
	output logic                       done,
	output logic [pde_pkg::WORD_W-1:0] quotient
);

	localparam int W     = pde_pkg::WORD_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic             neg_q;
	logic [W:0]       shifted;
	logic [W:0]       trial;
	logic [W-1:0]     a_mag;
	logic [W-1:0]     b_mag;

	assign a_mag   = dividend[W-1] ? (~dividend + W'(1)) : dividend;
	assign b_mag   = divisor[W-1]  ? (~divisor + W'(1))  : divisor;
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= a_mag;
			dvs_q <= b_mag;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops out
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	// minimum over minus one wraps back to the minimum here
	assign quotient = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

### sv/pde_datapath.sv
// pde_datapath: operand stack (top word in a register, the rest in RAM),
// arithmetic, divider and result register. Depends on pde_pkg, pde_ram,
// pde_divider.
module pde_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pde_pkg::pde_cmd_t           cmd,
	output pde_pkg::pde_stat_t          stat,
	input  logic [pde_pkg::SYM_W-1:0]   symbol,
	input  logic                        last,
	output logic signed [pde_pkg::WORD_W-1:0] value,
	output logic [pde_pkg::STAT_W-1:0]  status
);

	localparam int W  = pde_pkg::WORD_W;
	localparam int DW = pde_pkg::DEPTH_W;
	localparam int AW = pde_pkg::ADDR_W;
	localparam int SW = pde_pkg::SYM_W;

	logic [SW-1:0]                 sym_q;
	logic                          last_q;
	logic [W-1:0]                  tos_q;
	logic [DW-1:0]                 depth_q;
	logic [W-1:0]                  recent_q;
	logic [pde_pkg::STAT_W-1:0]    err_q;
	logic [W-1:0]                  val_out_q;
	logic [pde_pkg::STAT_W-1:0]    stat_out_q;

	logic [DW-1:0] depth_m1;
	logic [DW-1:0] depth_m2;
	logic [W-1:0]  a_word;
	logic [W-1:0]  product;
	logic [W-1:0]  res;
	logic          arith;
	logic [SW-1:0] digit;
	logic          ram_we;
	logic          div_done;
	logic [W-1:0]  div_q;

	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign digit    = sym_q - pde_pkg::CH_0;
	// the old top word spills into RAM when a new one is pushed
	assign ram_we   = cmd.push && (depth_q != '0);

	pde_ram #(
		.WIDTH(W),
		.DEPTH(pde_pkg::STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(depth_m1[AW-1:0]),
		.wdata(tos_q),
		.raddr(depth_m2[AW-1:0]),
		.rdata(a_word)
	);

	pde_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(a_word),
		.divisor (tos_q),
		.done    (div_done),
		.quotient(div_q)
	);

	assign product = a_word * tos_q;

	always_comb begin
		arith = 1'b1;
		case (sym_q)
			pde_pkg::CH_PLUS:  res = a_word + tos_q;
			pde_pkg::CH_MINUS: res = a_word - tos_q;
			pde_pkg::CH_STAR:  res = product;
			default: begin
				res   = recent_q;
				arith = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			recent_q <= '0;
			err_q    <= pde_pkg::ST_OK;
		end else begin
			if (cmd.push) begin
				depth_q <= depth_q + DW'(1);
			end
			if (cmd.apply) begin
				depth_q <= depth_m1;
				if (arith) begin
					recent_q <= res;
				end
			end
			if (cmd.div_commit) begin
				depth_q  <= depth_m1;
				recent_q <= div_q;
			end
			if (cmd.set_err) begin
				err_q <= cmd.err;
			end
			if (cmd.finish) begin
				depth_q  <= '0;
				recent_q <= '0;
				err_q    <= pde_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q  <= symbol;
			last_q <= last;
		end
		if (cmd.push) begin
			tos_q <= {{(W-SW){1'b0}}, digit};
		end
		if (cmd.apply) begin
			tos_q <= res;
		end
		if (cmd.div_commit) begin
			tos_q <= div_q;
		end
		if (cmd.finish) begin
			if (err_q != pde_pkg::ST_OK) begin
				val_out_q  <= '0;
				stat_out_q <= err_q;
			end else if (depth_q == DW'(1)) begin
				val_out_q  <= tos_q;
				stat_out_q <= pde_pkg::ST_OK;
			end else begin
				val_out_q  <= '0;
				stat_out_q <= pde_pkg::ST_MALFORMED;
			end
		end
	end

	always_comb begin
		stat.err_nz   = (err_q != pde_pkg::ST_OK);
		stat.digit    = sym_q inside {[pde_pkg::CH_0:pde_pkg::CH_9]};
		stat.full     = (depth_q == DW'(pde_pkg::STACK_DEPTH));
		stat.few      = (depth_q < DW'(2));
		stat.is_div   = (sym_q == pde_pkg::CH_SLASH);
		stat.b_zero   = (tos_q == '0);
		stat.div_done = div_done;
		stat.last     = last_q;
	end

	assign value  = val_out_q;
	assign status = stat_out_q;

endmodule

### sv/pde_ctrl.sv
// pde_ctrl: sequencer for the postfix evaluator; drives datapath commands
// and the channel handshakes. Depends on pde_pkg.
module pde_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pde_pkg::pde_stat_t stat,
	output pde_pkg::pde_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic [2:0] after;

	assign after     = stat.last ? S_FIN : S_IDLE;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = after;
				if (stat.err_nz) begin
					// expression already failed: just wait for its end
				end else if (stat.digit) begin
					if (stat.full) begin
						cmd.set_err = 1'b1;
						cmd.err     = pde_pkg::ST_OVERFLOW;
					end else begin
						cmd.push = 1'b1;
					end
				end else if (stat.few) begin
					cmd.set_err = 1'b1;
					cmd.err     = pde_pkg::ST_MALFORMED;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = after;
				if (!stat.is_div) begin
					cmd.apply = 1'b1;
				end else if (stat.b_zero) begin
					cmd.set_err = 1'b1;
					cmd.err     = pde_pkg::ST_DIV0;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_commit = 1'b1;
					state_d        = after;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
